>>> rtl/core/unacked_packet_retransmit_table_assert.svh
// Assertion macros for the retransmit table RTL.
// Depends on signals named clk and rst_n in the module that includes it.
`ifndef UNACKED_PACKET_RETRANSMIT_TABLE_ASSERT_SVH
`define UNACKED_PACKET_RETRANSMIT_TABLE_ASSERT_SVH

// Property must hold whenever the antecedent holds, same cycle.
`define UPRT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Property must hold in the cycle after the antecedent.
`define UPRT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/uprt_pkg.sv
// Shared types and constants for the retransmit table.
// No dependencies; used by uprt_cell and the top level.
package uprt_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int CMD_W         = 2;
    localparam int SEQ_W         = 32;
    localparam int STAMP_W       = 16;
    localparam int KIND_W        = 3;
    localparam int SLOT_W        = 4;
    localparam int OCC_W         = 5;
    localparam int TDATA_W       = 48;

    localparam logic [STAMP_W-1:0] TIMEOUT_RESET = 16'd2;

    // Command codes (s_tuser)
    localparam logic [CMD_W-1:0] CMD_SEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

    // Result kinds (m_tuser)
    localparam logic [KIND_W-1:0] KIND_STORED   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FULL     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ACKED    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NOTFOUND = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RETX     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_DONE     = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Broadcast controls from the sequencer to every cell
    typedef struct packed {
        logic store;   // accepted send word
        logic ack;     // accepted ack word
        logic start;   // tick accepted, launch scan token
        logic step;    // scan token advances this cycle
    } cell_ctrl_t;

    // Per-cell status back to the sequencer
    typedef struct packed {
        logic valid;   // entry occupied
        logic take;    // lowest free entry
        logic hit;     // lowest matching entry
        logic report;  // holds token and has timed out
    } cell_status_t;

endpackage

>>> rtl/core/uprt_cell.sv
// One table entry: valid bit, sequence number, time stamp and scan token.
// Depends on uprt_pkg; chained by the top level from slot 0 upward.
module uprt_cell
    import uprt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_ctrl_t         ctrl,
    input  logic [SEQ_W-1:0]   seq_in,
    input  logic [STAMP_W-1:0] now,
    input  logic [STAMP_W-1:0] timeout,
    input  logic               free_in,   // a lower slot is free
    output logic               free_out,
    input  logic               hit_in,    // a lower slot matched
    output logic               hit_out,
    input  logic               tok_in,
    output logic               tok_out,
    output cell_status_t       status,
    output logic [SEQ_W-1:0]   seq_out
);

    logic               valid_reg, valid_next;
    logic               tok_reg, tok_next;
    logic [SEQ_W-1:0]   seq_reg;
    logic [STAMP_W-1:0] stamp_reg;
    logic               take;
    logic               match;
    logic               hit;
    logic               expired;
    logic [STAMP_W-1:0] age;

    // Priority chains: lowest free slot and lowest matching slot
    assign take     = !valid_reg && !free_in;
    assign free_out = free_in || !valid_reg;
    assign match    = valid_reg && (seq_reg == seq_in);
    assign hit      = match && !hit_in;
    assign hit_out  = hit_in || match;

    // Age test with modular wrap
    assign age     = now - stamp_reg;
    assign expired = valid_reg && (age >= timeout);

    // Valid bit and token next values
    always_comb
    begin
        valid_next = valid_reg;
        if (ctrl.store && take)
        begin
            valid_next = 1'b1;
        end
        else if (ctrl.ack && hit)
        begin
            valid_next = 1'b0;
        end
        tok_next = tok_reg;
        if (ctrl.start || ctrl.step)
        begin
            tok_next = tok_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    // Payload: written on store, stamp refreshed on retransmit
    always_ff @(posedge clk)
    begin
        if (ctrl.store && take)
        begin
            seq_reg   <= seq_in;
            stamp_reg <= now;
        end
        else if (ctrl.step && tok_reg && expired)
        begin
            stamp_reg <= now;
        end
    end

    assign tok_out       = tok_reg;
    assign seq_out       = seq_reg;
    assign status.valid  = valid_reg;
    assign status.take   = take;
    assign status.hit    = hit;
    assign status.report = tok_reg && expired;

endmodule

>>> rtl/core/unacked_packet_retransmit_table.sv
// Top level of the retransmit table: sequencer, output register, cell chain.
// Depends on uprt_pkg, uprt_cell and unacked_packet_retransmit_table_assert.svh.
//
// Usage:
//   s_* channel carries commands: s_tuser is the command (send, ack, tick),
//   s_tdata the sequence number. m_* channel carries results: m_tuser is the
//   result kind, m_tlast marks the final result of a command, m_tdata packs
//   sequence number, slot and occupancy. cfg_* writes timeout_ticks; it is
//   always ready and is to be written only while the table is idle.
//   A send or ack word yields its one result in the cycle after it is
//   taken; a slot search is a priority ripple along the cell chain, so the
//   next word is taken at once if the output register drains.
//   A tick passes a token along the chain, one slot per cycle while the
//   output register can take a result: the tick is accepted, the token
//   visits each slot in turn, then the done result is issued and the
//   table returns to idle. Slots that have not timed out are still
//   visited by the token.
//   Reset empties the table, clears time to zero and sets the timeout to 2.
//   When m_tready is low the result waits in the output register and the scan
//   holds its position; new commands wait until the table is idle again.
`include "unacked_packet_retransmit_table_assert.svh"

module unacked_packet_retransmit_table
    import uprt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [SEQ_W-1:0]   s_tdata,   // [31:0] seq_no
    input  logic [CMD_W-1:0]   s_tuser,   // [1:0] command
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [31:0] seq_no_out, [35:32] slot,
                                          // [40:36] occupancy, [47:41] zero
    output logic [KIND_W-1:0]  m_tuser,   // [2:0] kind
    output logic               m_tlast,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [STAMP_W-1:0] cfg_data   // [15:0] timeout_ticks
);

    localparam int OCW = $clog2(SLOTS + 1);

    state_t             state_reg, state_next;
    logic [STAMP_W-1:0] now_reg, now_next;
    logic [STAMP_W-1:0] timeout_reg;
    logic [OCW-1:0]     occ_reg, occ_next;

    logic               m_valid_reg, m_valid_next;
    logic [KIND_W-1:0]  m_kind_reg, m_kind_next;
    logic [SEQ_W-1:0]   m_seq_reg, m_seq_next;
    logic [SLOT_W-1:0]  m_slot_reg, m_slot_next;
    logic [OCC_W-1:0]   m_occ_reg, m_occ_next;
    logic               m_last_reg, m_last_next;

    logic               out_free;
    logic               acc;
    cell_ctrl_t         ctrl;

    logic [SLOTS:0]     free_chain;
    logic [SLOTS:0]     hit_chain;
    logic [SLOTS:0]     tok_chain;
    cell_status_t       status [SLOTS];
    logic [SEQ_W-1:0]   cell_seq [SLOTS];

    logic [SLOTS-1:0]   valid_vec;
    logic [SLOTS-1:0]   take_vec;
    logic [SLOTS-1:0]   tok_vec;
    logic               full;
    logic               found;
    logic               any_report;
    logic [SLOT_W-1:0]  take_slot;
    logic [SLOT_W-1:0]  hit_slot;
    logic [SLOT_W-1:0]  rep_slot;
    logic [SEQ_W-1:0]   rep_seq;

    // Handshakes
    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign acc       = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Cell chain
    assign free_chain[0] = 1'b0;
    assign hit_chain[0]  = 1'b0;
    assign tok_chain[0]  = ctrl.start;

    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        uprt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .seq_in   (s_tdata),
            .now      (now_reg),
            .timeout  (timeout_reg),
            .free_in  (free_chain[g]),
            .free_out (free_chain[g+1]),
            .hit_in   (hit_chain[g]),
            .hit_out  (hit_chain[g+1]),
            .tok_in   (tok_chain[g]),
            .tok_out  (tok_chain[g+1]),
            .status   (status[g]),
            .seq_out  (cell_seq[g])
        );
        assign valid_vec[g] = status[g].valid;
        assign take_vec[g]  = status[g].take;
        assign tok_vec[g]   = tok_chain[g+1];
    end

    assign full  = !free_chain[SLOTS];
    assign found = hit_chain[SLOTS];

    // Encode the selected cells; at most one of each kind is set
    always_comb
    begin
        take_slot  = '0;
        hit_slot   = '0;
        rep_slot   = '0;
        rep_seq    = '0;
        any_report = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (status[i].take)
            begin
                take_slot = take_slot | SLOT_W'(i);
            end
            if (status[i].hit)
            begin
                hit_slot = hit_slot | SLOT_W'(i);
            end
            if (status[i].report)
            begin
                rep_slot   = rep_slot | SLOT_W'(i);
                rep_seq    = rep_seq | cell_seq[i];
                any_report = 1'b1;
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc && (s_tuser == CMD_TICK))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (out_free && tok_chain[SLOTS])
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer: cell controls, result word, counters
    always_comb
    begin
        ctrl         = '0;
        now_next     = now_reg;
        occ_next     = occ_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_kind_next  = m_kind_reg;
        m_seq_next   = m_seq_reg;
        m_slot_next  = m_slot_reg;
        m_occ_next   = m_occ_reg;
        m_last_next  = m_last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    case (s_tuser)
                        CMD_SEND:
                        begin
                            ctrl.store   = 1'b1;
                            m_valid_next = 1'b1;
                            m_seq_next   = s_tdata;
                            m_last_next  = 1'b1;
                            if (full)
                            begin
                                m_kind_next = KIND_FULL;
                                m_slot_next = '0;
                                m_occ_next  = OCC_W'(occ_reg);
                            end
                            else
                            begin
                                occ_next    = occ_reg + OCW'(1);
                                m_kind_next = KIND_STORED;
                                m_slot_next = take_slot;
                                m_occ_next  = OCC_W'(occ_reg + OCW'(1));
                            end
                        end
                        CMD_ACK:
                        begin
                            ctrl.ack     = 1'b1;
                            m_valid_next = 1'b1;
                            m_seq_next   = s_tdata;
                            m_last_next  = 1'b1;
                            if (found)
                            begin
                                occ_next    = occ_reg - OCW'(1);
                                m_kind_next = KIND_ACKED;
                                m_slot_next = hit_slot;
                                m_occ_next  = OCC_W'(occ_reg - OCW'(1));
                            end
                            else
                            begin
                                m_kind_next = KIND_NOTFOUND;
                                m_slot_next = '0;
                                m_occ_next  = OCC_W'(occ_reg);
                            end
                        end
                        CMD_TICK:
                        begin
                            ctrl.start = 1'b1;
                            now_next   = now_reg + STAMP_W'(1);
                        end
                        default:
                        begin
                            // unused command: dropped silently
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (out_free)
                begin
                    ctrl.step = 1'b1;
                    if (any_report)
                    begin
                        m_valid_next = 1'b1;
                        m_kind_next  = KIND_RETX;
                        m_seq_next   = rep_seq;
                        m_slot_next  = rep_slot;
                        m_occ_next   = OCC_W'(occ_reg);
                        m_last_next  = 1'b0;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_kind_next  = KIND_DONE;
                    m_seq_next   = '0;
                    m_slot_next  = '0;
                    m_occ_next   = OCC_W'(occ_reg);
                    m_last_next  = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            now_reg     <= '0;
            occ_reg     <= '0;
            timeout_reg <= TIMEOUT_RESET;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            now_reg     <= now_next;
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                timeout_reg <= cfg_data;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        m_kind_reg <= m_kind_next;
        m_seq_reg  <= m_seq_next;
        m_slot_reg <= m_slot_next;
        m_occ_reg  <= m_occ_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {(TDATA_W - SEQ_W - SLOT_W - OCC_W)'(0), m_occ_reg, m_slot_reg, m_seq_reg};

    // Checks
    `UPRT_ASSERT_NOW(a_tok_onehot, 1'b1, $onehot0(tok_vec), "more than one scan token")
    `UPRT_ASSERT_NOW(a_tok_idle, state_reg == ST_IDLE, tok_vec == '0, "scan token while idle")
    `UPRT_ASSERT_NOW(a_occ_count, 1'b1, occ_reg == OCW'($countones(valid_vec)), "occ drift")
    `UPRT_ASSERT_NOW(a_take_onehot, 1'b1, $onehot0(take_vec), "several free slots selected")
    `UPRT_ASSERT_NEXT(a_tick_scan, acc && (s_tuser == CMD_TICK), state_reg == ST_SCAN, "no scan")

endmodule
